@@ hw/rtl/iff_pkg.sv @@
// Shared types, constants and helper functions of the integer field formatter.
package iff_pkg;

    // Default field limits, handed to the top level as parameter defaults.
    localparam int DEF_MAX_WIDTH     = 48;
    localparam int DEF_MAX_PRECISION = 40;

    // Stream widths.
    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 8;

    // Field counters hold up to 127, enough for any width or precision limit.
    localparam int CNT_W = 7;

    // Digit store: 22 digits cover 64-bit octal and 64-bit decimal.
    localparam int NUM_DIGITS = 22;
    localparam int DIG_CNT_W  = 5;
    localparam int DIG_W      = 4 * NUM_DIGITS;

    // Conversion codes.
    localparam logic [2:0] CMD_SDEC = 3'd0;
    localparam logic [2:0] CMD_UDEC = 3'd1;
    localparam logic [2:0] CMD_OCT  = 3'd2;
    localparam logic [2:0] CMD_HEXL = 3'd3;
    localparam logic [2:0] CMD_HEXU = 3'd4;

    // Argument size codes.
    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    // ASCII characters.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic prep;
        logic conv;
        logic norm;
        logic layout;
        logic emit;
    } iff_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bad_cmd;
        logic is_dec;
        logic conv_last;
        logic norm_done;
        logic rem_zero;
    } iff_status_t;

    // ASCII for one digit value, upper or lower case letters above nine.
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        begin
            if (d < 4'd10)
            begin
                c = CH_ZERO + {4'd0, d};
            end
            else if (upper)
            begin
                c = CH_UA + {4'd0, d} - 8'd10;
            end
            else
            begin
                c = CH_LA + {4'd0, d} - 8'd10;
            end
            return c;
        end
    endfunction

endpackage

@@ hw/rtl/iff_ctrl.sv @@
// Controller state machine of the integer field formatter.
module iff_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  iff_pkg::iff_status_t status,
    output iff_pkg::iff_cmd_t    cmd
);
    import iff_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_CONV   = 3'd2;
    localparam logic [2:0] ST_NORM   = 3'd3;
    localparam logic [2:0] ST_LAYOUT = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       valid_reg;
    logic       valid_next;
    logic       fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = valid_reg;
    // The output register can take a new character when it is empty or being drained.
    assign fire      = !valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (status.bad_cmd)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.prep   = 1'b1;
                    state_next = status.is_dec ? ST_CONV : ST_NORM;
                end
            end
            ST_CONV:
            begin
                cmd.conv = 1'b1;
                if (status.conv_last)
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (status.norm_done)
                begin
                    state_next = ST_LAYOUT;
                end
                else
                begin
                    cmd.norm = 1'b1;
                end
            end
            ST_LAYOUT:
            begin
                cmd.layout = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (fire)
                begin
                    if (status.rem_zero)
                    begin
                        valid_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.emit   = 1'b1;
                        valid_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

@@ hw/rtl/iff_datapath.sv @@
// Datapath of the integer field formatter: digit conversion, layout and character output.
module iff_datapath
#(
    parameter int MAX_WIDTH     = iff_pkg::DEF_MAX_WIDTH,
    parameter int MAX_PRECISION = iff_pkg::DEF_MAX_PRECISION
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  iff_pkg::iff_cmd_t     cmd,
    output iff_pkg::iff_status_t  status,
    input  logic [2:0]            in_cmd,
    input  logic [63:0]           in_value,
    input  logic [1:0]            in_size,
    input  logic                  in_left,
    input  logic                  in_plus,
    input  logic                  in_zpad,
    input  logic                  in_space,
    input  logic                  in_alt,
    input  logic [5:0]            in_width,
    input  logic                  in_hasp,
    input  logic [5:0]            in_prec,
    output logic [7:0]            ch,
    output logic                  last_char
);
    import iff_pkg::*;

    localparam logic [CNT_W-1:0] WIDTH_LIM = CNT_W'(MAX_WIDTH);
    localparam logic [CNT_W-1:0] PREC_LIM  = CNT_W'(MAX_PRECISION);

    // Item registers.
    logic [2:0]           conv_reg, conv_next;
    logic [63:0]          val_reg, val_next;
    logic [1:0]           size_reg, size_next;
    logic                 left_reg, left_next;
    logic                 plus_reg, plus_next;
    logic                 zpad_reg, zpad_next;
    logic                 space_reg, space_next;
    logic                 alt_reg, alt_next;
    logic                 hasp_reg, hasp_next;
    logic [CNT_W-1:0]     width_reg, width_next;
    logic [CNT_W-1:0]     prec_reg, prec_next;
    // Conversion registers.
    logic                 neg_reg, neg_next;
    logic                 mzero_reg, mzero_next;
    logic [DIG_W-1:0]     dig_reg, dig_next;
    logic [DIG_CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    // Layout counters.
    logic [CNT_W-1:0]     lead_reg, lead_next;
    logic [15:0]          pfx_reg, pfx_next;
    logic [1:0]           plen_reg, plen_next;
    logic [CNT_W-1:0]     zeros_reg, zeros_next;
    logic [DIG_CNT_W-1:0] dcnt_reg, dcnt_next;
    logic [CNT_W-1:0]     trail_reg, trail_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    // Output register.
    logic [7:0]           ch_reg, ch_next;
    logic                 last_reg, last_next;

    // Combinational helpers.
    logic [63:0]          mask;
    logic                 sign_bit;
    logic                 neg_w;
    logic [63:0]          mag;
    logic [DIG_W-1:0]     oct_dig;
    logic [DIG_W-1:0]     hex_dig;
    logic [DIG_W-1:0]     bcd_fix;
    logic [DIG_W+63:0]    bcd_shift;
    logic [6:0]           w_in, p_in;
    logic [DIG_CNT_W-1:0] eff_len;
    logic [CNT_W-1:0]     len_ext, plen_ext, zeros_w, used, blanks;
    logic [1:0]           plen_w;
    logic [15:0]          pfx_w;
    logic                 zpad_eff;
    logic                 is_oct, is_hex, upper;

    assign is_oct = (conv_reg == CMD_OCT);
    assign is_hex = (conv_reg == CMD_HEXL) || (conv_reg == CMD_HEXU);
    assign upper  = (conv_reg == CMD_HEXU);

    assign status.bad_cmd   = (conv_reg > CMD_HEXU);
    assign status.is_dec    = (conv_reg == CMD_SDEC) || (conv_reg == CMD_UDEC);
    assign status.conv_last = (bit_cnt_reg == CNT_W'(1));
    assign status.norm_done = !((len_reg > DIG_CNT_W'(1)) && (dig_reg[DIG_W-1 -: 4] == 4'd0));
    assign status.rem_zero  = (rem_reg == '0);

    assign ch        = ch_reg;
    assign last_char = last_reg;

    // Argument size decoding.
    always_comb
    begin
        unique case (size_reg)
            SIZE_8:
            begin
                mask     = 64'h0000_0000_0000_00FF;
                sign_bit = val_reg[7];
            end
            SIZE_16:
            begin
                mask     = 64'h0000_0000_0000_FFFF;
                sign_bit = val_reg[15];
            end
            SIZE_32:
            begin
                mask     = 64'h0000_0000_FFFF_FFFF;
                sign_bit = val_reg[31];
            end
            default:
            begin
                mask     = 64'hFFFF_FFFF_FFFF_FFFF;
                sign_bit = val_reg[63];
            end
        endcase
        neg_w = (conv_reg == CMD_SDEC) && sign_bit;
        mag   = neg_w ? ((~val_reg + 64'd1) & mask) : (val_reg & mask);
    end

    // Octal and hex digits come straight from the magnitude bits.
    always_comb
    begin
        oct_dig = '0;
        hex_dig = '0;
        for (int k = 0; k < 21; k++)
        begin
            oct_dig[4*k +: 4] = {1'b0, mag[3*k +: 3]};
        end
        oct_dig[4*21 +: 4] = {3'b000, mag[63]};
        for (int k = 0; k < 16; k++)
        begin
            hex_dig[4*k +: 4] = mag[4*k +: 4];
        end
    end

    // One double-dabble step: correct every BCD digit, then shift in the next bit.
    always_comb
    begin
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            if (dig_reg[4*k +: 4] >= 4'd5)
            begin
                bcd_fix[4*k +: 4] = dig_reg[4*k +: 4] + 4'd3;
            end
            else
            begin
                bcd_fix[4*k +: 4] = dig_reg[4*k +: 4];
            end
        end
        bcd_shift = {bcd_fix, val_reg} << 1;
    end

    // Field layout from the digit count, prefix and flags.
    always_comb
    begin
        eff_len = (mzero_reg && hasp_reg && (prec_reg == '0)) ? '0 : len_reg;
        len_ext = CNT_W'(eff_len);
        plen_w  = 2'd0;
        pfx_w   = '0;
        if (conv_reg == CMD_SDEC)
        begin
            if (neg_reg)
            begin
                plen_w = 2'd1;
                pfx_w  = {CH_MINUS, 8'h00};
            end
            else if (plus_reg)
            begin
                plen_w = 2'd1;
                pfx_w  = {CH_PLUS, 8'h00};
            end
            else if (space_reg)
            begin
                plen_w = 2'd1;
                pfx_w  = {CH_SPACE, 8'h00};
            end
        end
        else if (alt_reg && is_oct)
        begin
            if ((eff_len == '0) || !mzero_reg)
            begin
                plen_w = 2'd1;
                pfx_w  = {CH_ZERO, 8'h00};
            end
        end
        else if (alt_reg && is_hex && !mzero_reg)
        begin
            plen_w = 2'd2;
            pfx_w  = {CH_ZERO, upper ? CH_UX : CH_LX};
        end
        plen_ext = CNT_W'(plen_w);
        // The leading octal zero counts toward the precision.
        if (hasp_reg && (prec_reg > len_ext))
        begin
            zeros_w = prec_reg - len_ext - ((is_oct && (plen_w == 2'd1)) ? CNT_W'(1) : '0);
        end
        else
        begin
            zeros_w = '0;
        end
        used     = len_ext + plen_ext + zeros_w;
        blanks   = (width_reg > used) ? (width_reg - used) : '0;
        zpad_eff = zpad_reg && !left_reg && !hasp_reg;
    end

    always_comb
    begin
        conv_next    = conv_reg;
        val_next     = val_reg;
        size_next    = size_reg;
        left_next    = left_reg;
        plus_next    = plus_reg;
        zpad_next    = zpad_reg;
        space_next   = space_reg;
        alt_next     = alt_reg;
        hasp_next    = hasp_reg;
        width_next   = width_reg;
        prec_next    = prec_reg;
        neg_next     = neg_reg;
        mzero_next   = mzero_reg;
        dig_next     = dig_reg;
        len_next     = len_reg;
        bit_cnt_next = bit_cnt_reg;
        lead_next    = lead_reg;
        pfx_next     = pfx_reg;
        plen_next    = plen_reg;
        zeros_next   = zeros_reg;
        dcnt_next    = dcnt_reg;
        trail_next   = trail_reg;
        rem_next     = rem_reg;
        ch_next      = ch_reg;
        last_next    = last_reg;
        w_in         = {1'b0, in_width};
        p_in         = {1'b0, in_prec};

        if (cmd.load)
        begin
            conv_next  = in_cmd;
            val_next   = in_value;
            size_next  = in_size;
            left_next  = in_left;
            plus_next  = in_plus;
            zpad_next  = in_zpad;
            space_next = in_space;
            alt_next   = in_alt;
            hasp_next  = in_hasp;
            width_next = (CNT_W'(w_in) > WIDTH_LIM) ? WIDTH_LIM : CNT_W'(w_in);
            prec_next  = (CNT_W'(p_in) > PREC_LIM) ? PREC_LIM : CNT_W'(p_in);
        end

        if (cmd.prep)
        begin
            neg_next   = neg_w;
            mzero_next = ((val_reg & mask) == 64'd0);
            len_next   = DIG_CNT_W'(NUM_DIGITS);
            if (is_oct)
            begin
                dig_next = oct_dig;
            end
            else if (is_hex)
            begin
                dig_next = hex_dig;
            end
            else
            begin
                // Decimal: top-align the magnitude for the bit-serial BCD conversion.
                dig_next = '0;
                unique case (size_reg)
                    SIZE_8:
                    begin
                        val_next     = mag << 56;
                        bit_cnt_next = CNT_W'(8);
                    end
                    SIZE_16:
                    begin
                        val_next     = mag << 48;
                        bit_cnt_next = CNT_W'(16);
                    end
                    SIZE_32:
                    begin
                        val_next     = mag << 32;
                        bit_cnt_next = CNT_W'(32);
                    end
                    default:
                    begin
                        val_next     = mag;
                        bit_cnt_next = CNT_W'(64);
                    end
                endcase
            end
        end

        if (cmd.conv)
        begin
            dig_next     = bcd_shift[DIG_W+63 -: DIG_W];
            val_next     = bcd_shift[63:0];
            bit_cnt_next = bit_cnt_reg - CNT_W'(1);
        end

        if (cmd.norm)
        begin
            dig_next = dig_reg << 4;
            len_next = len_reg - DIG_CNT_W'(1);
        end

        if (cmd.layout)
        begin
            pfx_next   = pfx_w;
            plen_next  = plen_w;
            dcnt_next  = eff_len;
            rem_next   = used + blanks;
            if (zpad_eff)
            begin
                zeros_next = zeros_w + blanks;
                lead_next  = '0;
                trail_next = '0;
            end
            else
            begin
                zeros_next = zeros_w;
                lead_next  = left_reg ? '0 : blanks;
                trail_next = left_reg ? blanks : '0;
            end
        end

        if (cmd.emit)
        begin
            rem_next  = rem_reg - CNT_W'(1);
            last_next = (rem_reg == CNT_W'(1));
            priority if (lead_reg != '0)
            begin
                ch_next   = CH_SPACE;
                lead_next = lead_reg - CNT_W'(1);
            end
            else if (plen_reg != 2'd0)
            begin
                ch_next   = pfx_reg[15:8];
                pfx_next  = pfx_reg << 8;
                plen_next = plen_reg - 2'd1;
            end
            else if (zeros_reg != '0)
            begin
                ch_next    = CH_ZERO;
                zeros_next = zeros_reg - CNT_W'(1);
            end
            else if (dcnt_reg != '0)
            begin
                ch_next   = digit_char(dig_reg[DIG_W-1 -: 4], upper);
                dig_next  = dig_reg << 4;
                dcnt_next = dcnt_reg - DIG_CNT_W'(1);
            end
            else
            begin
                ch_next    = CH_SPACE;
                trail_next = trail_reg - CNT_W'(1);
            end
        end
    end

    // Control counters are reset; payload registers are not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_reg    <= CMD_SDEC;
            rem_reg     <= '0;
            bit_cnt_reg <= '0;
            len_reg     <= '0;
            lead_reg    <= '0;
            plen_reg    <= '0;
            zeros_reg   <= '0;
            dcnt_reg    <= '0;
            trail_reg   <= '0;
        end
        else
        begin
            conv_reg    <= conv_next;
            rem_reg     <= rem_next;
            bit_cnt_reg <= bit_cnt_next;
            len_reg     <= len_next;
            lead_reg    <= lead_next;
            plen_reg    <= plen_next;
            zeros_reg   <= zeros_next;
            dcnt_reg    <= dcnt_next;
            trail_reg   <= trail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        size_reg  <= size_next;
        left_reg  <= left_next;
        plus_reg  <= plus_next;
        zpad_reg  <= zpad_next;
        space_reg <= space_next;
        alt_reg   <= alt_next;
        hasp_reg  <= hasp_next;
        width_reg <= width_next;
        prec_reg  <= prec_next;
        neg_reg   <= neg_next;
        mzero_reg <= mzero_next;
        dig_reg   <= dig_next;
        pfx_reg   <= pfx_next;
        ch_reg    <= ch_next;
        last_reg  <= last_next;
    end

endmodule

@@ hw/rtl/integer_field_formatter.sv @@
// Integer field formatter top level. An item passes through setup, bit-serial conversion
// for a decimal argument, leading-zero stripping and layout before the first character,
// then one character per cycle while the output takes them.
// Throughput: one item at a time, the next taken once the last character has been transferred.
// Reset: rst_n clears the controller to idle with no output pending.
module integer_field_formatter
#(
    parameter int MAX_WIDTH     = iff_pkg::DEF_MAX_WIDTH,
    parameter int MAX_PRECISION = iff_pkg::DEF_MAX_PRECISION
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Input stream: one conversion request per transfer.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata fields from bit 0 up: value[63:0], size_code[65:64], left_just[66],
    // force_sign[67], zero_pad[68], space_sign[69], alternate[70], field_width[76:71],
    // has_precision[77], min_digits[83:78], unused[87:84].
    input  logic [iff_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser fields from bit 0 up: cmd[2:0].
    input  logic [iff_pkg::S_TUSER_W-1:0] s_tuser,
    // Output stream: one character per transfer, tlast on the final one of the field.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata fields from bit 0 up: ch[7:0].
    output logic [iff_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import iff_pkg::*;

    iff_cmd_t    dp_cmd;
    iff_status_t dp_status;

    // The controller sequences setup, conversion, stripping, layout and output.
    iff_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    // The datapath holds the item, the digit store, the layout counters and the
    // output character register, which stays stable while a transfer is stalled.
    iff_datapath
    #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_PRECISION (MAX_PRECISION)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .in_cmd    (s_tuser),
        .in_value  (s_tdata[63:0]),
        .in_size   (s_tdata[65:64]),
        .in_left   (s_tdata[66]),
        .in_plus   (s_tdata[67]),
        .in_zpad   (s_tdata[68]),
        .in_space  (s_tdata[69]),
        .in_alt    (s_tdata[70]),
        .in_width  (s_tdata[76:71]),
        .in_hasp   (s_tdata[77]),
        .in_prec   (s_tdata[83:78]),
        .ch        (m_tdata),
        .last_char (m_tlast)
    );

endmodule
